// File: rtl/core/cpu8080_data_transfer_unit_assert.svh
// Assertion macros for the 8080 data-transfer unit.
// Used by the top level; no other dependencies.
`ifndef CPU8080_DATA_TRANSFER_UNIT_ASSERT_SVH
`define CPU8080_DATA_TRANSFER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DTU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTU_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTU_ASSERT(label, clk, rst_n, prop, msg)
`define DTU_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/dtu_pkg.sv
// 8080 data-transfer unit package: kinds, register selectors, opcodes, widths
// No dependencies.
package dtu_pkg;
	localparam int MemAddrBits = 16;
	localparam int DataW = 8;

	localparam logic [1:0] KIND_EXEC  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [2:0] SEL_B   = 3'd0;
	localparam logic [2:0] SEL_C   = 3'd1;
	localparam logic [2:0] SEL_D   = 3'd2;
	localparam logic [2:0] SEL_E   = 3'd3;
	localparam logic [2:0] SEL_H   = 3'd4;
	localparam logic [2:0] SEL_L   = 3'd5;
	localparam logic [2:0] SEL_MEM = 3'd6;
	localparam logic [2:0] SEL_A   = 3'd7;

	localparam logic [7:0] OP_HLT  = 8'h76;
	localparam logic [7:0] OP_LDAXB = 8'h0A;
	localparam logic [7:0] OP_LDAXD = 8'h1A;
	localparam logic [7:0] OP_STAXB = 8'h02;
	localparam logic [7:0] OP_STAXD = 8'h12;
	localparam logic [7:0] OP_LDA  = 8'h3A;
	localparam logic [7:0] OP_STA  = 8'h32;
	localparam logic [7:0] OP_LHLD = 8'h2A;
	localparam logic [7:0] OP_SHLD = 8'h22;
	localparam logic [7:0] OP_XCHG = 8'hEB;
endpackage

// File: rtl/core/dtu_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module dtu_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write one word when enabled and always read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: rtl/core/cpu8080_data_transfer_unit.sv
// 8080 data-transfer unit: one instruction or memory access per input transaction,
// with a single-port synchronous byte memory (1 access per cycle, registered read).
// The input is held busy by each item's memory accesses: items that only change
// registers or write one byte do not hold it, an item that reads one byte (memory
// read, MOV r,M, LDAX, LDA) holds it in ST_RD1, SHLD for its second write and LHLD
// in ST_RD1 and ST_RD2. A finished result waits in pend_q and moves into the output
// register once that is free, so one more item is taken while a result waits there;
// then the input stalls until the output drains. Register-only items otherwise run
// back to back at one per cycle. The memory is not cleared after reset and must be
// written before it is read. Depends on dtu_pkg, dtu_ram.
`include "cpu8080_data_transfer_unit_assert.svh"
module cpu8080_data_transfer_unit #(
	parameter int MEM_ADDR_BITS = dtu_pkg::MemAddrBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode[7:0], operand_low[15:8], operand_high[23:16],
	// mem_addr[39:24], mem_data[47:40]
	input  logic [47:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l [55:0],
	// stack_ptr_out[71:56], prog_counter_out[87:72], cycle_total[119:88],
	// mem_byte[127:120], status[128], zero[135:129]
	output logic [135:0] m_axis_tdata
);
	typedef enum logic [1:0] {ST_IDLE, ST_RD1, ST_RD2} state_t;

	state_t state_q;
	logic [7:0] a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0] sp_q, pc_q;
	logic [31:0] cyc_q;
	logic [7:0] rd_byte_q;
	logic stat_q;
	logic [2:0] dst_q;
	logic [1:0] rkind_q; // 0 sel write, 1 LHLD low, 2 read kind
	logic [15:0] addr2_q;
	logic [7:0] hold_q;
	logic busy_q; // SHLD second write pending
	logic pend_q; // finished result waiting for the output register

	// decode of incoming item
	logic [1:0] kind;
	logic [7:0] op, lo, hi, wdat;
	logic [15:0] maddr, imm;
	logic [2:0] ddst, dsrc;
	assign kind  = s_axis_tuser;
	assign op    = s_axis_tdata[7:0];
	assign lo    = s_axis_tdata[15:8];
	assign hi    = s_axis_tdata[23:16];
	assign maddr = s_axis_tdata[39:24];
	assign wdat  = s_axis_tdata[47:40];
	assign imm   = {hi, lo};
	assign ddst  = op[5:3];
	assign dsrc  = op[2:0];

	logic out_free, accept, emit, shld_go;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !busy_q && (!pend_q || out_free);
	assign accept = s_axis_tvalid && s_axis_tready;

	// memory port
	logic ram_we;
	logic [15:0] ram_a16;
	logic [7:0] ram_wd, ram_rd;
	dtu_ram #(.Width(8), .Depth(1 << MEM_ADDR_BITS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_a16[MEM_ADDR_BITS-1:0]),
		.wdata(ram_wd), .rdata(ram_rd)
	);

	function automatic logic [7:0] rsel(input logic [2:0] s, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
		input logic [7:0] e, input logic [7:0] h, input logic [7:0] l);
		logic [7:0] r;
		unique case (s)
			dtu_pkg::SEL_B: r = b;
			dtu_pkg::SEL_C: r = c;
			dtu_pkg::SEL_D: r = d;
			dtu_pkg::SEL_E: r = e;
			dtu_pkg::SEL_H: r = h;
			dtu_pkg::SEL_L: r = l;
			default: r = a;
		endcase
		return r;
	endfunction

	// classify and pick the memory access of each cycle, also for second bytes
	logic is_mov, is_mvi, is_lxi, valid_op, need_rd;
	always_comb begin
		is_mov = (op[7:6] == 2'b01) && (op != dtu_pkg::OP_HLT);
		is_mvi = (op & 8'hC7) == 8'h06;
		is_lxi = (op & 8'hCF) == 8'h01;
		valid_op = is_mov || is_mvi || is_lxi || op == dtu_pkg::OP_LDAXB ||
			op == dtu_pkg::OP_LDAXD || op == dtu_pkg::OP_STAXB ||
			op == dtu_pkg::OP_STAXD || op == dtu_pkg::OP_LDA ||
			op == dtu_pkg::OP_STA || op == dtu_pkg::OP_LHLD ||
			op == dtu_pkg::OP_SHLD || op == dtu_pkg::OP_XCHG;
		ram_we = 1'b0;
		ram_a16 = maddr;
		ram_wd = wdat;
		need_rd = 1'b0;
		if (busy_q) begin
			ram_we = 1'b1;
			ram_a16 = addr2_q;
			ram_wd = hold_q;
		end else if (state_q == ST_RD1 && rkind_q == 2'd1) begin
			ram_a16 = addr2_q;
		end else if (accept) begin
			if (kind == dtu_pkg::KIND_WRITE) begin
				ram_we = 1'b1;
			end else if (kind == dtu_pkg::KIND_READ) begin
				need_rd = 1'b1;
			end else if (kind == dtu_pkg::KIND_EXEC) begin
				if (is_mov && dsrc == dtu_pkg::SEL_MEM) begin
					ram_a16 = {h_q, l_q}; need_rd = 1'b1;
				end else if (is_mov && ddst == dtu_pkg::SEL_MEM) begin
					ram_a16 = {h_q, l_q}; ram_we = 1'b1;
					ram_wd = rsel(dsrc, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
				end else if (is_mvi && ddst == dtu_pkg::SEL_MEM) begin
					ram_a16 = {h_q, l_q}; ram_we = 1'b1; ram_wd = lo;
				end else if (op == dtu_pkg::OP_LDAXB || op == dtu_pkg::OP_LDAXD) begin
					ram_a16 = op[4] ? {d_q, e_q} : {b_q, c_q}; need_rd = 1'b1;
				end else if (op == dtu_pkg::OP_STAXB || op == dtu_pkg::OP_STAXD) begin
					ram_a16 = op[4] ? {d_q, e_q} : {b_q, c_q};
					ram_we = 1'b1; ram_wd = a_q;
				end else if (op == dtu_pkg::OP_LDA || op == dtu_pkg::OP_LHLD) begin
					ram_a16 = imm; need_rd = 1'b1;
				end else if (op == dtu_pkg::OP_STA) begin
					ram_a16 = imm; ram_we = 1'b1; ram_wd = a_q;
				end else if (op == dtu_pkg::OP_SHLD) begin
					ram_a16 = imm; ram_we = 1'b1; ram_wd = l_q;
				end
			end
		end
	end

	// combinational next architectural state for an accepted item
	logic [7:0] na, nb, nc, nd, ne, nh, nl, mvv;
	logic [15:0] nsp, npc;
	logic [31:0] ncyc;
	logic nstat;
	logic [1:0] len;
	logic [4:0] cost;
	always_comb begin
		na = a_q; nb = b_q; nc = c_q; nd = d_q; ne = e_q; nh = h_q; nl = l_q;
		nsp = sp_q; len = 2'd0; cost = 5'd0; nstat = 1'b0;
		mvv = is_mvi ? lo : rsel(dsrc, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
		if (kind == dtu_pkg::KIND_EXEC) begin
			if (!valid_op) begin
				nstat = 1'b1;
			end else if (is_mov || is_mvi) begin
				len = is_mvi ? 2'd2 : 2'd1;
				cost = is_mvi ? ((ddst == dtu_pkg::SEL_MEM) ? 5'd10 : 5'd7)
					: ((ddst == dtu_pkg::SEL_MEM || dsrc == dtu_pkg::SEL_MEM) ? 5'd7 : 5'd5);
				if (!(is_mov && dsrc == dtu_pkg::SEL_MEM)) begin
					unique case (ddst)
						dtu_pkg::SEL_B: nb = mvv;
						dtu_pkg::SEL_C: nc = mvv;
						dtu_pkg::SEL_D: nd = mvv;
						dtu_pkg::SEL_E: ne = mvv;
						dtu_pkg::SEL_H: nh = mvv;
						dtu_pkg::SEL_L: nl = mvv;
						dtu_pkg::SEL_A: na = mvv;
						default: ;
					endcase
				end
			end else if (is_lxi) begin
				len = 2'd3; cost = 5'd10;
				unique case (op[5:4])
					2'd0: begin nb = hi; nc = lo; end
					2'd1: begin nd = hi; ne = lo; end
					2'd2: begin nh = hi; nl = lo; end
					default: nsp = imm;
				endcase
			end else if (op == dtu_pkg::OP_XCHG) begin
				len = 2'd1; cost = 5'd4;
				nd = h_q; nh = d_q; ne = l_q; nl = e_q;
			end else if (op == dtu_pkg::OP_LDA || op == dtu_pkg::OP_STA) begin
				len = 2'd3; cost = 5'd13;
			end else if (op == dtu_pkg::OP_LHLD || op == dtu_pkg::OP_SHLD) begin
				len = 2'd3; cost = 5'd16;
			end else begin
				len = 2'd1; cost = 5'd7;
			end
		end
		npc = pc_q + {14'd0, len};
		ncyc = cyc_q + {27'd0, cost};
	end

	assign shld_go = accept && kind == dtu_pkg::KIND_EXEC && op == dtu_pkg::OP_SHLD;

	// sequence items, hold state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			h_q <= '0; l_q <= '0; sp_q <= '0; pc_q <= '0; cyc_q <= '0;
			rd_byte_q <= '0;
			stat_q <= 1'b0;
			dst_q <= dtu_pkg::SEL_A;
			rkind_q <= 2'd0;
			addr2_q <= '0;
			hold_q <= '0;
		end else begin
			// move a finished result into the output register
			m_axis_tvalid <= (pend_q && out_free) || (m_axis_tvalid && !m_axis_tready);
			pend_q <= emit || (pend_q && !out_free);
			if (pend_q && out_free) begin
				m_axis_tdata <= {7'd0, stat_q, rd_byte_q, cyc_q, pc_q, sp_q,
					l_q, h_q, e_q, d_q, c_q, b_q, a_q};
			end
			busy_q <= shld_go;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						a_q <= na; b_q <= nb; c_q <= nc; d_q <= nd; e_q <= ne;
						h_q <= nh; l_q <= nl; sp_q <= nsp; pc_q <= npc; cyc_q <= ncyc;
						rd_byte_q <= '0;
						stat_q <= nstat;
						if (shld_go) begin
							addr2_q <= imm + 16'd1;
							hold_q <= h_q;
						end
						if (need_rd) begin
							state_q <= ST_RD1;
							dst_q <= (kind == dtu_pkg::KIND_READ) ? dtu_pkg::SEL_MEM :
								(op == dtu_pkg::OP_LHLD) ? dtu_pkg::SEL_L :
								is_mov ? ddst : dtu_pkg::SEL_A;
							rkind_q <= (kind == dtu_pkg::KIND_READ) ? 2'd2 :
								(op == dtu_pkg::OP_LHLD) ? 2'd1 : 2'd0;
							addr2_q <= imm + 16'd1;
						end
					end
				end
				ST_RD1: begin
					unique case (dst_q)
						dtu_pkg::SEL_B: b_q <= ram_rd;
						dtu_pkg::SEL_C: c_q <= ram_rd;
						dtu_pkg::SEL_D: d_q <= ram_rd;
						dtu_pkg::SEL_E: e_q <= ram_rd;
						dtu_pkg::SEL_H: h_q <= ram_rd;
						dtu_pkg::SEL_L: l_q <= ram_rd;
						dtu_pkg::SEL_A: a_q <= ram_rd;
						default: rd_byte_q <= ram_rd;
					endcase
					state_q <= (rkind_q == 2'd1) ? ST_RD2 : ST_IDLE;
				end
				ST_RD2: begin
					h_q <= ram_rd;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result is complete once its item has finished
	assign emit = (accept && !need_rd) || (state_q == ST_RD1 && rkind_q != 2'd1) ||
		(state_q == ST_RD2);

	`DTU_ASSERT(a_no_accept_busy, clk, arst_n, (state_q != ST_IDLE) |-> !s_axis_tready, "accept while reading")
	`DTU_ASSERT(a_lhld_two, clk, arst_n, (state_q == ST_RD2) |-> ($past(state_q) == ST_RD1), "bad LHLD sequence")
	`DTU_ASSERT(a_shld_wr, clk, arst_n, busy_q |-> ram_we, "SHLD second write lost")
endmodule
